// ===== rtl/pwsm_pkg.sv =====
// ---------------------------------------------------------------------------
// pwsm_pkg
// Shared types and constants of the pulse window speed mean block.
// ---------------------------------------------------------------------------
package pwsm_pkg;

   // field widths
   localparam int INTERVAL_W = 16;
   localparam int PULSES_W   = 8;
   localparam int DIST_W     = 16;
   localparam int SPEED_W    = 16;
   localparam int SUM_W      = 20;
   localparam int PROD_W     = DIST_W + PULSES_W;
   localparam int NUM_W      = 38;

   // arithmetic constants
   localparam logic [13:0]      SPEED_SCALE = 14'd9216;
   localparam logic [SUM_W-1:0] SUM_MAX     = 20'd655350;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

   // one quotient bit per divider step
   localparam int DIV_STEPS = NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // channel payloads
   typedef struct packed {
      logic [INTERVAL_W-1:0] pulse_interval;
      logic [PULSES_W-1:0]   window_pulses;
   } req_payload_type;

   typedef struct packed {
      logic [SPEED_W-1:0] mean_speed;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIST_W-1:0] pulse_distance;
   } csr_payload_type;

   // divider result toward the sequencer
   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_result_type;

endpackage

// ===== rtl/pwsm_chan_if.sv =====
// ---------------------------------------------------------------------------
// pwsm_chan_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface pwsm_chan_if #(
   parameter type payload_type = logic [15:0]
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/pwsm_ring.sv =====
// ---------------------------------------------------------------------------
// pwsm_ring
// Interval ring memory with one valid bit per entry; unwritten entries
// read as zero.
// ---------------------------------------------------------------------------
module pwsm_ring #(
   parameter int WINDOW = 8,
   parameter int SLOT_W = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [SLOT_W-1:0]               rd_addr,
   output logic [pwsm_pkg::INTERVAL_W-1:0] rd_data,
   input  logic                            wr_en,
   input  logic [SLOT_W-1:0]               wr_addr,
   input  logic [pwsm_pkg::INTERVAL_W-1:0] wr_data
);
   import pwsm_pkg::*;

   logic [INTERVAL_W-1:0] mem [WINDOW];
   logic [WINDOW-1:0]     valid_ff;
   logic [INTERVAL_W-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/pwsm_divider.sv =====
// ---------------------------------------------------------------------------
// pwsm_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pwsm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pwsm_pkg::NUM_W-1:0] dividend,
   input  logic [pwsm_pkg::SUM_W-1:0] divisor,
   output pwsm_pkg::div_result_type   result
);
   import pwsm_pkg::*;

   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SUM_W:0]       shifted;
   logic [SUM_W+1:0]     diff;
   logic                 fits;

   // shared trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      fits    = ~diff[SUM_W+1];
   end

   // step control
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[SUM_W-1:0];
         end else begin
            rem_in = shifted[SUM_W-1:0];
         end
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

// ===== rtl/pulse_window_speed_mean.sv =====
// ---------------------------------------------------------------------------
// pulse_window_speed_mean
// Sliding-window mean of wheel-pulse intervals turned into a raw speed.
//
// Each request transaction carries one pulse interval and a pulse count.
// The block keeps the last WINDOW intervals in a ring and a running sum,
// clamped to 0..655350, then answers with
// mean_speed = pulse_distance * 9216 * window_pulses / sum, truncated and
// saturated to 65535 (65535 when the sum is zero). A request passes the
// ring read at acceptance, sum update and product, divider load, the
// bit-serial restoring divider, pick-up of its done flag, and the load of
// the response register, which waits while an earlier response is pending.
// The next request can be taken in the cycle after that load. The request
// side is not ready while a request is in work; a finished response waits
// in its own register, so the next request is taken while it is pending.
// The pulse_distance register is written through the csr channel, which
// is always ready; the user must write it only while no request is in
// work, and the block itself does not enforce this.
// ---------------------------------------------------------------------------
module pulse_window_speed_mean #(
   parameter int WINDOW = 8
) (
   input  logic       clock,
   input  logic       reset,
   pwsm_chan_if.sink   req_chan,
   pwsm_chan_if.source rsp_chan,
   pwsm_chan_if.sink   csr_chan
);
   import pwsm_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [DIST_W-1:0]     dist_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [PULSES_W-1:0]   pulses_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]    speed_ff;
   logic [SPEED_W-1:0]    speed_in;

   req_payload_type       req_pl;
   csr_payload_type       csr_pl;
   rsp_payload_type       rsp_pl;
   logic                  req_take;
   logic                  rsp_take;
   logic                  rsp_free;
   logic [INTERVAL_W-1:0] oldest;
   logic [SUM_W+1:0]      sum_trial;
   logic [NUM_W-1:0]      dividend;
   logic                  div_start;
   div_result_type        div_res;

   assign req_pl   = req_chan.payload;
   assign csr_pl   = csr_chan.payload;
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_take;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // interval ring
   pwsm_ring #(
      .WINDOW (WINDOW),
      .SLOT_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (slot_ff),
      .rd_data (oldest),
      .wr_en   (state_ff == ST_SUM),
      .wr_addr (slot_ff),
      .wr_data (interval_ff)
   );

   // shared iterative divider; scale by 9216 = 8192 + 1024 as two shifts
   assign dividend  = (NUM_W'(prod_ff) << 13) + (NUM_W'(prod_ff) << 10);
   assign div_start = (state_ff == ST_LOAD);

   pwsm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (sum_ff),
      .result   (div_res)
   );

   // running sum with clamping at zero and at the top
   always_comb begin
      sum_trial = {2'b00, sum_ff} + (SUM_W+2)'(interval_ff) - (SUM_W+2)'(oldest);
      if (sum_trial[SUM_W+1]) begin
         sum_in = '0;
      end else if (sum_trial[SUM_W:0] > {1'b0, SUM_MAX}) begin
         sum_in = SUM_MAX;
      end else begin
         sum_in = sum_trial[SUM_W-1:0];
      end
   end

   // speed saturation
   always_comb begin
      if ((sum_ff == '0) || (|div_res.quotient[NUM_W-1:SPEED_W])) begin
         speed_in = SPEED_MAX;
      end else begin
         speed_in = div_res.quotient[SPEED_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         sum_ff       <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_SUM) begin
            sum_ff <= sum_in;
         end
         if (csr_chan.valid) begin
            dist_ff <= csr_pl.pulse_distance;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         interval_ff <= req_pl.pulse_interval;
         pulses_ff   <= req_pl.window_pulses;
      end
      if (state_ff == ST_SUM) begin
         prod_ff <= dist_ff * pulses_ff;
      end
      if ((state_ff == ST_OUT) && rsp_free) begin
         speed_ff <= speed_in;
      end
   end

   assign rsp_pl.mean_speed = speed_ff;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.payload  = rsp_pl;

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_window_speed_mean. It opens with a short
// table of directed transactions: zero window sum, saturated quotient, zero
// pulse count, and distance extremes. Randomized phases follow. Each phase
// first writes a new pulse_distance while the block is idle. A local window
// model predicts every mean_speed, and responses are checked in order. The
// request side sends in bursts with random gaps, except in every fourth phase;
// responses stall in their own patterns, and one long hold-off backs the block up.
// ---------------------------------------------------------------------------
module testbench;

   import pwsm_pkg::*;

   localparam int WINDOW          = 8;
   localparam int N_DIRECTED      = 22;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 153;
   localparam int HOLD_AFTER      = 400;
   localparam int HOLD_CYCLES     = 600;
   localparam int DRAIN_CYCLES    = 100;
   localparam int CYCLE_LIMIT     = 1000000;

   typedef enum logic { ROW_CSR, ROW_REQ } row_kind_type;
   typedef enum logic [1:0] {
      RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC
   } stall_mode_type;

   // word is the interval for a request row and the distance for a csr row
   typedef struct packed {
      row_kind_type          kind;
      logic [INTERVAL_W-1:0] word;
      logic [PULSES_W-1:0]   pulses;
      logic                  pinned;
      logic [SPEED_W-1:0]    speed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pwsm_chan_if #(.payload_type(req_payload_type)) req_if ();
   pwsm_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   pwsm_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   pulse_window_speed_mean #(.WINDOW(WINDOW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #1 clock = ~clock;

   // window model state
   logic [INTERVAL_W-1:0] window_ring [WINDOW];
   int                    window_slot;
   logic [SUM_W-1:0]      window_sum;
   logic [DIST_W-1:0]     distance_model;

   logic [SPEED_W-1:0] mean_speed_queue [$];

   // side band of the request being offered: a typed-in expectation
   logic               req_pinned;
   logic [SPEED_W-1:0] req_pinned_speed;

   int error_count = 0;
   int rsp_count   = 0;
   int cycle_count = 0;

   stim_row_type directed_rows [N_DIRECTED];

   task automatic report_failure(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   // one window step: sum update with clamping, quotient, ring write
   function automatic logic [SPEED_W-1:0] advance_window(
      input logic [INTERVAL_W-1:0] interval,
      input logic [PULSES_W-1:0]   pulses
   );
      longint unsigned oldest;
      longint unsigned acc;
      longint unsigned dec;
      longint unsigned num;
      longint unsigned speed;
      oldest = window_ring[window_slot];
      if (interval >= oldest) begin
         acc = window_sum + (interval - oldest);
         if (acc > SUM_MAX) acc = SUM_MAX;
      end else begin
         dec = oldest - interval;
         acc = (window_sum > dec) ? window_sum - dec : 0;
      end
      window_sum = acc[SUM_W-1:0];
      num = longint'(distance_model) * longint'(SPEED_SCALE) * longint'(pulses);
      if (acc == 0) speed = SPEED_MAX;
      else speed = num / acc;
      if (speed > SPEED_MAX) speed = SPEED_MAX;
      window_ring[window_slot] = interval;
      window_slot = (window_slot == WINDOW - 1) ? 0 : window_slot + 1;
      return speed[SPEED_W-1:0];
   endfunction

   // mostly realistic intervals, with extremes and tiny values mixed in
   function automatic logic [INTERVAL_W-1:0] pick_interval();
      int sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0:       return '0;
         1:       return '1;
         2:       return INTERVAL_W'($urandom_range(0, 15));
         3, 4, 5, 6, 7, 8, 9, 10: return INTERVAL_W'($urandom_range(200, 4000));
         default: return INTERVAL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [PULSES_W-1:0] pick_pulses();
      int sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return PULSES_W'(WINDOW);
         default:    return PULSES_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [DIST_W-1:0] pick_distance(input int phase);
      case (phase)
         0: return '1;
         1: return '0;
         2: return 16'd1;
         default: begin
            if ($urandom_range(0, 1) == 0) return DIST_W'($urandom_range(1, 400));
            return DIST_W'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // offer one request transaction and hold it until accepted
   task automatic send_request(
      input logic [INTERVAL_W-1:0] interval,
      input logic [PULSES_W-1:0]   pulses,
      input logic                  pinned,
      input logic [SPEED_W-1:0]    speed
   );
      @(negedge clock);
      req_if.valid                  <= 1'b1;
      req_if.payload.pulse_interval <= interval;
      req_if.payload.window_pulses  <= pulses;
      req_pinned                    <= pinned;
      req_pinned_speed              <= speed;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // stop offering and wait until every expected response has arrived
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (mean_speed_queue.size() != 0) @(negedge clock);
   endtask

   task automatic write_distance(input logic [DIST_W-1:0] distance);
      drain_results();
      csr_if.valid                  <= 1'b1;
      csr_if.payload.pulse_distance <= distance;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // monitor: check responses, then predict for newly accepted requests
   always @(posedge clock) begin
      logic [SPEED_W-1:0] predicted;
      logic [SPEED_W-1:0] want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (mean_speed_queue.size() == 0) begin
               report_failure($sformatf("response mean_speed=%0d with nothing expected",
                                        rsp_if.payload.mean_speed));
            end else begin
               want = mean_speed_queue.pop_front();
               if (rsp_if.payload.mean_speed !== want)
                  report_failure($sformatf("response %0d: mean_speed=%0d, expected %0d",
                                           rsp_count, rsp_if.payload.mean_speed, want));
            end
         end
         if (csr_if.valid && csr_if.ready)
            distance_model = csr_if.payload.pulse_distance;
         if (req_if.valid && req_if.ready) begin
            predicted = advance_window(req_if.payload.pulse_interval,
                                       req_if.payload.window_pulses);
            mean_speed_queue.push_back(req_pinned ? req_pinned_speed : predicted);
         end
      end
   end

   // receiver: stall patterns of its own, plus one long hold-off
   initial begin : receiver
      stall_mode_type mode;
      int             mode_left;
      int             tick;
      int             hold_left;
      bit             hold_done;
      rsp_if.ready = 1'b0;
      mode      = RX_ALWAYS;
      mode_left = 0;
      tick      = 0;
      hold_left = 0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && rsp_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 250);
               tick      = 0;
            end
            mode_left--;
            tick++;
            case (mode)
               RX_ALWAYS: rsp_if.ready <= 1'b1;
               RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_if.ready <= ((tick % 7) < 3);
            endcase
         end
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      int                    phase;
      int                    left;
      int                    burst;
      int                    k;
      int                    zero_run;
      logic [INTERVAL_W-1:0] interval;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      csr_if.valid     = 1'b0;
      csr_if.payload   = '0;
      req_pinned       = 1'b0;
      req_pinned_speed = '0;
      for (int i = 0; i < WINDOW; i++) window_ring[i] = '0;
      window_slot    = 0;
      window_sum     = '0;
      distance_model = '0;

      directed_rows = '{
         // zero sum right after reset, with both pulse extremes
         '{ROW_REQ, 16'd0,     8'd0,   1'b1, 16'hFFFF},
         '{ROW_REQ, 16'd0,     8'd255, 1'b1, 16'hFFFF},
         '{ROW_CSR, 16'hFFFF,  8'd0,   1'b0, 16'd0},
         // quotient far above the speed ceiling
         '{ROW_REQ, 16'hFFFF,  8'd255, 1'b1, 16'hFFFF},
         // zero pulse count gives zero speed
         '{ROW_REQ, 16'hFFFF,  8'd0,   1'b1, 16'd0},
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_CSR, 16'd1,     8'd0,   1'b0, 16'd0},
         // ring full of maximum intervals
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_REQ, 16'hFFFF,  8'd1,   1'b0, 16'd0},
         '{ROW_REQ, 16'd0,     8'd1,   1'b0, 16'd0},
         '{ROW_CSR, 16'd300,   8'd0,   1'b0, 16'd0},
         '{ROW_REQ, 16'd1,     8'd128, 1'b0, 16'd0},
         '{ROW_REQ, 16'd255,   8'd8,   1'b0, 16'd0},
         '{ROW_REQ, 16'd256,   8'd200, 1'b0, 16'd0},
         '{ROW_REQ, 16'd12345, 8'd77,  1'b0, 16'd0},
         '{ROW_REQ, 16'hAAAA,  8'h55,  1'b0, 16'd0},
         '{ROW_REQ, 16'h5555,  8'hAA,  1'b0, 16'd0},
         '{ROW_CSR, 16'd0,     8'd0,   1'b0, 16'd0},
         // zero distance with a nonzero sum
         '{ROW_REQ, 16'd1000,  8'd255, 1'b1, 16'd0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_distance(directed_rows[i].word);
         else
            send_request(directed_rows[i].word, directed_rows[i].pulses,
                         directed_rows[i].pinned, directed_rows[i].speed);
      end

      // random phases; every fourth phase sends without gaps
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_distance(pick_distance(phase));
         left     = ITEMS_PER_PHASE;
         zero_run = 0;
         while (left > 0) begin
            burst = (phase % 4 == 3) ? left : $urandom_range(1, 12);
            for (k = 0; k < burst && left > 0; k++) begin
               // occasional run of zero intervals walks the sum back to zero
               if (zero_run == 0 && $urandom_range(0, 39) == 0)
                  zero_run = $urandom_range(8, 10);
               if (zero_run > 0) begin
                  interval = '0;
                  zero_run--;
               end else begin
                  interval = pick_interval();
               end
               send_request(interval, pick_pulses(), 1'b0, '0);
               left--;
            end
            if (phase % 4 != 3)
               idle_cycles(($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 6));
         end
      end

      // end of run
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mean_speed_queue.size() != 0)
         report_failure($sformatf("%0d expected responses never arrived",
                                  mean_speed_queue.size()));
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pwsm_pkg.sv
rtl/pwsm_chan_if.sv
rtl/pwsm_ring.sv
rtl/pwsm_divider.sv
rtl/pulse_window_speed_mean.sv
verif/testbench.sv
